### design/bvm_pkg.sv
`timescale 1ns / 1ps

package bvm_pkg;

    // Field widths
    localparam int CODE_W   = 12;
    localparam int TIME_W   = 32;
    localparam int MV_W     = 15;
    localparam int GAIN_W   = 24;
    localparam int OFFS_W   = 13;
    localparam int DELAY_W  = 16;
    localparam int EVENT_W  = 16;
    localparam int STATUS_W = 3;
    localparam int CONV_W   = CODE_W + GAIN_W;
    localparam int Q_FRAC   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERVOLT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOOD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_DELAY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_DELAY = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 24'd300028;
    localparam logic [OFFS_W-1:0]  OFFSET_RST     = 13'd0;
    localparam logic [MV_W-1:0]    OVERVOLT_RST   = 15'd15000;
    localparam logic [MV_W-1:0]    FULL_RST       = 15'd13200;
    localparam logic [MV_W-1:0]    GOOD_RST       = 15'd12400;
    localparam logic [MV_W-1:0]    LOW_RST        = 15'd11800;
    localparam logic [DELAY_W-1:0] LOW_DELAY_RST  = 16'd30000;
    localparam logic [DELAY_W-1:0] CRIT_DELAY_RST = 16'd10000;

    // Voltage constants in millivolts
    localparam logic [CONV_W-Q_FRAC-1:0] VALID_LO_MV = 20'd8000;
    localparam logic [CONV_W-Q_FRAC-1:0] VALID_HI_MV = 20'd16000;
    localparam logic [MV_W-1:0]          DEFAULT_MV  = 15'd12000;
    localparam logic [MV_W-1:0]          MIN_RST_MV  = 15'd15000;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_CHARGING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GOOD     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOW      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CRITICAL = 3'd4;

    // Parameter defaults
    localparam int RING_DEPTH_DEF        = 16;
    localparam int OVERVOLT_DELAY_MS_DEF = 5000;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic convert;
        logic update;
        logic div_run;
        logic commit;
    } bvm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
    } bvm_stat_t;

endpackage

### design/bvm_ram.sv
`timescale 1ns / 1ps

module bvm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bvm_ctrl.sv
`timescale 1ns / 1ps

module bvm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bvm_pkg::bvm_stat_t stat,
    output bvm_pkg::bvm_cmd_t  cmd
);

    import bvm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CAL,
        S_DIV,
        S_POST
    } state_t;

    state_t state_reg, state_next;

    // Sequence one sample through convert, update, divide and commit
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.convert = 1'b1;
                state_next  = S_CAL;
            end
            S_CAL: begin
                cmd.update = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_POST;
                end else begin
                    cmd.div_run = 1'b1;
                end
            end
            S_POST: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

### design/bvm_dp.sv
`timescale 1ns / 1ps

module bvm_dp #(
    parameter int RING_DEPTH        = bvm_pkg::RING_DEPTH_DEF,
    parameter int OVERVOLT_DELAY_MS = bvm_pkg::OVERVOLT_DELAY_MS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [bvm_pkg::CODE_W-1:0]      s_adc_code,
    input  logic [bvm_pkg::TIME_W-1:0]      s_now_ms,
    input  bvm_pkg::bvm_cmd_t               cmd,
    output bvm_pkg::bvm_stat_t              stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bvm_pkg::MV_W-1:0]        m_smoothed_mv,
    output logic [bvm_pkg::STATUS_W-1:0]    m_status,
    output logic                            m_charging,
    output logic                            m_low_alert,
    output logic                            m_critical_alert,
    output logic                            m_overvolt_alert,
    output logic [bvm_pkg::TIME_W-1:0]      m_time_at_status_ms,
    output logic [bvm_pkg::TIME_W-1:0]      m_charging_total_ms,
    output logic [bvm_pkg::MV_W-1:0]        m_min_mv,
    output logic [bvm_pkg::MV_W-1:0]        m_max_mv,
    output logic [bvm_pkg::EVENT_W-1:0]     m_low_event_count,
    output logic [bvm_pkg::EVENT_W-1:0]     m_critical_event_count
);

    import bvm_pkg::*;

    localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = MV_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int MVC_W  = CONV_W - Q_FRAC;
    localparam int CAL_W  = MV_W + 2;

    localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(RING_DEPTH);
    localparam logic [TIME_W-1:0] OV_DELAY   = TIME_W'(OVERVOLT_DELAY_MS);
    localparam logic [CAL_W-1:0]  CAL_MAX    = CAL_W'((1 << MV_W) - 1);
    localparam logic [EVENT_W-1:0] EVENT_MAX = '1;

    // Configuration registers
    logic [GAIN_W-1:0]  gain_reg;
    logic [OFFS_W-1:0]  offset_reg;
    logic [MV_W-1:0]    overvolt_reg, full_reg, good_reg, low_reg;
    logic [DELAY_W-1:0] low_delay_reg, crit_delay_reg;

    // Sample payload
    logic [CODE_W-1:0] code_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CONV_W-1:0] conv_reg;

    // Ring and monitor state
    logic [AW-1:0]       wp_reg;
    logic                filled_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [MV_W-1:0]     last_smoothed_reg;
    logic [STATUS_W-1:0] last_status_reg;
    logic [TIME_W-1:0]   change_time_reg;
    logic                chg_flag_reg;
    logic [TIME_W-1:0]   chg_start_reg;
    logic [TIME_W-1:0]   chg_total_reg;
    logic                low_al_reg, crit_al_reg, over_al_reg;
    logic [EVENT_W-1:0]  low_events_reg, crit_events_reg;
    logic [MV_W-1:0]     min_reg, max_reg;

    // Divider
    logic [SUM_W-1:0]  div_num_reg;
    logic [CNT_W-1:0]  div_den_reg;
    logic [CNT_W-1:0]  div_rem_reg;
    logic [STEP_W-1:0] div_cnt_reg;

    logic m_valid_reg;

    // Ring memory
    logic [MV_W-1:0] ram_rdata;
    logic [MV_W-1:0] cal_mv;

    bvm_ram #(
        .WIDTH (MV_W),
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (aclk),
        .we    (cmd.update),
        .waddr (wp_reg),
        .wdata (cal_mv),
        .re    (cmd.capture),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    // Validate, replace and calibrate the converted reading
    logic [MVC_W-1:0]        conv_mv;
    logic                    in_window;
    logic [MV_W-1:0]         reading;
    logic signed [CAL_W-1:0] cal_wide;
    logic [MV_W-1:0]         old_mv;
    logic [SUM_W-1:0]        sum_next;
    logic [CNT_W-1:0]        wp_inc;
    logic                    wp_wrap;
    logic [CNT_W-1:0]        count;

    always_comb begin
        conv_mv   = conv_reg[CONV_W-1:Q_FRAC];
        in_window = (conv_mv >= VALID_LO_MV) && (conv_mv <= VALID_HI_MV);
        if (in_window) begin
            reading = conv_mv[MV_W-1:0];
        end else if (last_smoothed_reg != '0) begin
            reading = last_smoothed_reg;
        end else begin
            reading = DEFAULT_MV;
        end
        cal_wide = $signed({2'b00, reading})
                 + $signed({{(CAL_W-OFFS_W){offset_reg[OFFS_W-1]}}, offset_reg});
        if (cal_wide < 0) begin
            cal_mv = '0;
        end else if (cal_wide > $signed(CAL_MAX)) begin
            cal_mv = CAL_MAX[MV_W-1:0];
        end else begin
            cal_mv = cal_wide[MV_W-1:0];
        end
        // Entries never written before the first wrap read as zero
        old_mv   = filled_reg ? ram_rdata : '0;
        sum_next = sum_reg - SUM_W'(old_mv) + SUM_W'(cal_mv);
        wp_inc   = CNT_W'(wp_reg) + CNT_W'(1);
        wp_wrap  = (wp_inc == DEPTH_CNT);
        count    = filled_reg ? DEPTH_CNT : wp_inc;
    end

    // One restoring divider step
    logic [CNT_W:0]   rem_sh;
    logic             q_bit;
    logic [CNT_W-1:0] rem_next;

    always_comb begin
        rem_sh = {div_rem_reg, div_num_reg[SUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, div_den_reg});
        if (q_bit) begin
            rem_next = CNT_W'(rem_sh - {1'b0, div_den_reg});
        end else begin
            rem_next = rem_sh[CNT_W-1:0];
        end
    end

    // Classify the average and work out timers and alerts
    logic [MV_W-1:0]     smoothed;
    logic [STATUS_W-1:0] status;
    logic                charging;
    logic [TIME_W-1:0]   change_time_next;
    logic [TIME_W-1:0]   chg_total_next;
    logic                low_cond, crit_cond, over_cond;
    logic                low_raise, crit_raise, over_raise;

    always_comb begin
        smoothed = div_num_reg[MV_W-1:0];
        if (smoothed > overvolt_reg) begin
            status = ST_CHARGING;
        end else if (smoothed >= full_reg) begin
            status = ST_FULL;
        end else if (smoothed >= good_reg) begin
            status = ST_GOOD;
        end else if (smoothed >= low_reg) begin
            status = ST_LOW;
        end else begin
            status = ST_CRITICAL;
        end
        change_time_next = (status != last_status_reg) ? now_reg : change_time_reg;
        charging         = (smoothed > full_reg);
        chg_total_next   = chg_total_reg;
        if (!charging && chg_flag_reg) begin
            chg_total_next = chg_total_reg + (now_reg - chg_start_reg);
        end
        low_cond   = (status == ST_LOW);
        crit_cond  = (status == ST_CRITICAL);
        over_cond  = (smoothed > overvolt_reg);
        low_raise  = low_cond && !low_al_reg && (now_reg > TIME_W'(low_delay_reg));
        crit_raise = crit_cond && !crit_al_reg && (now_reg > TIME_W'(crit_delay_reg));
        over_raise = over_cond && !over_al_reg && (now_reg > OV_DELAY);
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= GAIN_RST;
            offset_reg     <= OFFSET_RST;
            overvolt_reg   <= OVERVOLT_RST;
            full_reg       <= FULL_RST;
            good_reg       <= GOOD_RST;
            low_reg        <= LOW_RST;
            low_delay_reg  <= LOW_DELAY_RST;
            crit_delay_reg <= CRIT_DELAY_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GAIN:       gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_OFFSET:     offset_reg     <= cfg_wdata[OFFS_W-1:0];
                REG_OVERVOLT:   overvolt_reg   <= cfg_wdata[MV_W-1:0];
                REG_FULL:       full_reg       <= cfg_wdata[MV_W-1:0];
                REG_GOOD:       good_reg       <= cfg_wdata[MV_W-1:0];
                REG_LOW:        low_reg        <= cfg_wdata[MV_W-1:0];
                REG_LOW_DELAY:  low_delay_reg  <= cfg_wdata[DELAY_W-1:0];
                REG_CRIT_DELAY: crit_delay_reg <= cfg_wdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the beat and convert
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg <= s_adc_code;
            now_reg  <= s_now_ms;
        end
        if (cmd.convert) begin
            conv_reg <= CONV_W'(code_reg) * CONV_W'(gain_reg);
        end
    end

    // Divider operands and quotient
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            div_num_reg <= sum_next;
            div_den_reg <= count;
            div_rem_reg <= '0;
        end else if (cmd.div_run) begin
            div_num_reg <= {div_num_reg[SUM_W-2:0], q_bit};
            div_rem_reg <= rem_next;
        end
    end

    // Divider step count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.update) begin
            div_cnt_reg <= STEP_W'(SUM_W);
        end else if (cmd.div_run) begin
            div_cnt_reg <= div_cnt_reg - STEP_W'(1);
        end
    end

    // Ring, extremes and monitor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg            <= '0;
            filled_reg        <= 1'b0;
            sum_reg           <= '0;
            min_reg           <= MIN_RST_MV;
            max_reg           <= '0;
            last_smoothed_reg <= '0;
            last_status_reg   <= ST_GOOD;
            change_time_reg   <= '0;
            chg_flag_reg      <= 1'b0;
            chg_start_reg     <= '0;
            chg_total_reg     <= '0;
            low_al_reg        <= 1'b0;
            crit_al_reg       <= 1'b0;
            over_al_reg       <= 1'b0;
            low_events_reg    <= '0;
            crit_events_reg   <= '0;
        end else begin
            if (cmd.update) begin
                sum_reg <= sum_next;
                if (wp_wrap) begin
                    wp_reg     <= '0;
                    filled_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_inc[AW-1:0];
                end
                if (cal_mv < min_reg) begin
                    min_reg <= cal_mv;
                end
                if (cal_mv > max_reg) begin
                    max_reg <= cal_mv;
                end
            end
            if (cmd.commit) begin
                last_smoothed_reg <= smoothed;
                last_status_reg   <= status;
                change_time_reg   <= change_time_next;
                chg_flag_reg      <= charging;
                chg_total_reg     <= chg_total_next;
                if (charging && !chg_flag_reg) begin
                    chg_start_reg <= now_reg;
                end
                low_al_reg  <= low_cond && (low_al_reg || low_raise);
                crit_al_reg <= crit_cond && (crit_al_reg || crit_raise);
                over_al_reg <= over_cond && (over_al_reg || over_raise);
                if (low_raise && low_events_reg != EVENT_MAX) begin
                    low_events_reg <= low_events_reg + EVENT_W'(1);
                end
                if (crit_raise && crit_events_reg != EVENT_MAX) begin
                    crit_events_reg <= crit_events_reg + EVENT_W'(1);
                end
            end
        end
    end

    // Output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_smoothed_mv          <= smoothed;
            m_status               <= status;
            m_charging             <= charging;
            m_low_alert            <= low_cond && (low_al_reg || low_raise);
            m_critical_alert       <= crit_cond && (crit_al_reg || crit_raise);
            m_overvolt_alert       <= over_cond && (over_al_reg || over_raise);
            m_time_at_status_ms    <= now_reg - change_time_next;
            m_charging_total_ms    <= chg_total_next;
            m_min_mv               <= min_reg;
            m_max_mv               <= max_reg;
            m_low_event_count      <= (low_raise && low_events_reg != EVENT_MAX)
                                      ? low_events_reg + EVENT_W'(1) : low_events_reg;
            m_critical_event_count <= (crit_raise && crit_events_reg != EVENT_MAX)
                                      ? crit_events_reg + EVENT_W'(1) : crit_events_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign stat.div_done = (div_cnt_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

### design/battery_voltage_monitor.sv
`timescale 1ns / 1ps
// Each beat is captured, converted, calibrated into the ring and averaged by a bit-serial
// divider over the SUM_W-bit ring sum, SUM_W = 15 + clog2(RING_DEPTH+1). A new sample is
// taken only once the last is committed, and commit waits for a free output; a finished
// result waits in the output register while the next sample is taken and worked.
// Reset: synchronous, active low; control, configuration and monitor registers return to
// defaults, the ring reads as empty through fill tracking, so no clearing pass is needed.

module battery_voltage_monitor #(
    parameter int RING_DEPTH        = bvm_pkg::RING_DEPTH_DEF,
    parameter int OVERVOLT_DELAY_MS = bvm_pkg::OVERVOLT_DELAY_MS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bvm_pkg::CODE_W-1:0]      s_adc_code,
    input  logic [bvm_pkg::TIME_W-1:0]      s_now_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bvm_pkg::MV_W-1:0]        m_smoothed_mv,
    output logic [bvm_pkg::STATUS_W-1:0]    m_status,
    output logic                            m_charging,
    output logic                            m_low_alert,
    output logic                            m_critical_alert,
    output logic                            m_overvolt_alert,
    output logic [bvm_pkg::TIME_W-1:0]      m_time_at_status_ms,
    output logic [bvm_pkg::TIME_W-1:0]      m_charging_total_ms,
    output logic [bvm_pkg::MV_W-1:0]        m_min_mv,
    output logic [bvm_pkg::MV_W-1:0]        m_max_mv,
    output logic [bvm_pkg::EVENT_W-1:0]     m_low_event_count,
    output logic [bvm_pkg::EVENT_W-1:0]     m_critical_event_count
);

    import bvm_pkg::*;

    bvm_cmd_t  cmd;
    bvm_stat_t stat;

    // Sequencer
    bvm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Conversion, ring average, divider and monitor state
    bvm_dp #(
        .RING_DEPTH        (RING_DEPTH),
        .OVERVOLT_DELAY_MS (OVERVOLT_DELAY_MS)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata),
        .s_adc_code             (s_adc_code),
        .s_now_ms               (s_now_ms),
        .cmd                    (cmd),
        .stat                   (stat),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_smoothed_mv          (m_smoothed_mv),
        .m_status               (m_status),
        .m_charging             (m_charging),
        .m_low_alert            (m_low_alert),
        .m_critical_alert       (m_critical_alert),
        .m_overvolt_alert       (m_overvolt_alert),
        .m_time_at_status_ms    (m_time_at_status_ms),
        .m_charging_total_ms    (m_charging_total_ms),
        .m_min_mv               (m_min_mv),
        .m_max_mv               (m_max_mv),
        .m_low_event_count      (m_low_event_count),
        .m_critical_event_count (m_critical_event_count)
    );

endmodule
